// ===== rtl/vtpg_pkg.sv =====
package vtpg_pkg;

	localparam int COORD_BITS_DEF   = 12;
	localparam int TILE_PITCH_DEF   = 64;
	localparam int GLYPH_SIZE_DEF   = 64;
	localparam int STROKE_WIDTH_DEF = 4;

	// geometry math width, holds twice the largest frame size
	localparam int DIM_W     = 16;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int GRID_N    = 5;
	// cycles for the geometry registers to follow a register write
	localparam logic [2:0] SETTLE_CYCLES = 3'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN = 2'd0,
		REG_WIDTH   = 2'd1,
		REG_HEIGHT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PAT_SMPTE   = 3'd0,
		PAT_STRIPES = 3'd1,
		PAT_GRAY    = 3'd2,
		PAT_CHECKER = 3'd3,
		PAT_RAMP    = 3'd4,
		PAT_RGBRAMP = 3'd5,
		PAT_HATCH   = 3'd6,
		PAT_GLYPH   = 3'd7
	} pat_t;

	localparam logic [7:0]  LVL75 = 8'd191;
	localparam logic [23:0] WHITE = 24'hFF_FF_FF;
	localparam logic [23:0] BLACK = 24'h00_00_00;

	// ceil(2^32 / c): exact quotient for dividends below 2^16
	localparam logic [31:0] RCP_3  = 32'((64'd1 << 32) / 3 + 64'd1);
	localparam logic [31:0] RCP_5  = 32'((64'd1 << 32) / 5 + 64'd1);
	localparam logic [31:0] RCP_6  = 32'((64'd1 << 32) / 6 + 64'd1);
	localparam logic [31:0] RCP_7  = 32'((64'd1 << 32) / 7 + 64'd1);
	localparam logic [31:0] RCP_11 = 32'((64'd1 << 32) / 11 + 64'd1);
	localparam logic [31:0] RCP_12 = 32'((64'd1 << 32) / 12 + 64'd1);
	localparam logic [31:0] RCP_60 = 32'((64'd1 << 32) / 60 + 64'd1);
	localparam logic [31:0] RCP_80 = 32'((64'd1 << 32) / 80 + 64'd1);

	typedef logic [DIM_W-1:0] dim_t;

	// frame geometry, all derived from the register values
	typedef struct packed {
		pat_t                   pattern;
		dim_t                   width;
		dim_t                   height;
		dim_t                   den;
		logic [5:0][DIM_W-1:0]  bar7;
		logic [9:0][DIM_W-1:0]  bar11;
		dim_t                   top_h;
		dim_t                   mid_h;
		dim_t                   w6;
		dim_t                   w6w12;
		dim_t                   cursor;
		dim_t                   right;
		logic                   pulse_ok;
		logic [2:0][DIM_W-1:0]  pls;
		logic [2:0][DIM_W-1:0]  ple;
		logic                   band_ok;
		dim_t                   band1;
		dim_t                   band2;
		dim_t                   band3;
		logic [4:0][DIM_W-1:0]  gx0;
		logic [4:0][DIM_W-1:0]  gx0s;
		logic [4:0][DIM_W-1:0]  gx1;
		logic [4:0][DIM_W-1:0]  gx1s;
		logic [4:0]             gxv;
		logic [4:0]             gxr;
		logic [4:0][DIM_W-1:0]  gy0;
		logic [4:0][DIM_W-1:0]  gy1;
		logic [4:0][DIM_W-1:0]  gby;
		logic [4:0][DIM_W-1:0]  gbys;
		logic [4:0]             gyv;
		logic [4:0]             gyb;
	} geom_t;

	// color before the ramp value is merged in
	typedef struct packed {
		logic [23:0] rgb;
		logic [2:0]  mask;     // red, green, blue take the ramp value
		logic        outside;
	} base_t;

	function automatic dim_t div_rcp(input dim_t a, input logic [31:0] rcp);
		logic [47:0] p;
		p = 48'(a) * 48'(rcp);
		return p[47:32];
	endfunction

	function automatic logic [23:0] top_bar(input logic [2:0] i);
		logic [23:0] c;
		case (i)
			3'd0:    c = {LVL75, LVL75, LVL75};
			3'd1:    c = {LVL75, LVL75, 8'd0};
			3'd2:    c = {8'd0, LVL75, LVL75};
			3'd3:    c = {8'd0, LVL75, 8'd0};
			3'd4:    c = {LVL75, 8'd0, LVL75};
			3'd5:    c = {LVL75, 8'd0, 8'd0};
			default: c = {8'd0, 8'd0, LVL75};
		endcase
		return c;
	endfunction

	function automatic logic [23:0] mid_bar(input logic [2:0] i);
		logic [23:0] c;
		case (i)
			3'd0:    c = {8'd0, 8'd0, LVL75};
			3'd2:    c = {LVL75, 8'd0, LVL75};
			3'd4:    c = {8'd0, LVL75, LVL75};
			3'd6:    c = {LVL75, LVL75, LVL75};
			default: c = BLACK;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] gray_step(input logic [3:0] i);
		logic [7:0] v;
		case (i)
			4'd0:    v = 8'd0;
			4'd1:    v = 8'd26;
			4'd2:    v = 8'd51;
			4'd3:    v = 8'd77;
			4'd4:    v = 8'd102;
			4'd5:    v = 8'd128;
			4'd6:    v = 8'd153;
			4'd7:    v = 8'd179;
			4'd8:    v = 8'd204;
			4'd9:    v = 8'd230;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] pulse_level(input int k);
		logic [7:0] v;
		case (k)
			0:       v = 8'd5;
			1:       v = 8'd0;
			default: v = 8'd10;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/vtpg_if.sv =====
interface vtpg_in_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface vtpg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       outside;

	modport source (output valid, output red, output green, output blue, output outside,
		input ready);
	modport sink   (input valid, input red, input green, input blue, input outside,
		output ready);
endinterface

// ===== rtl/vtpg_setup.sv =====
module vtpg_setup #(
	parameter int GLYPH_SIZE   = vtpg_pkg::GLYPH_SIZE_DEF,
	parameter int STROKE_WIDTH = vtpg_pkg::STROKE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtpg_pkg::CFG_W-1:0]     cfg_data,
	output vtpg_pkg::geom_t                geom,
	output logic                           busy
);
	import vtpg_pkg::*;

	localparam dim_t HALF_D   = DIM_W'(GLYPH_SIZE / 2);
	localparam dim_t STROKE_D = DIM_W'(STROKE_WIDTH);
	localparam dim_t SHALF_D  = DIM_W'(STROKE_WIDTH / 2);

	pat_t             pattern_q;
	logic [CFG_W-1:0] width_q, height_q;
	logic [2:0]       settle_q;
	dim_t             wd, hd;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_SMPTE;
			width_q   <= CFG_W'(640);
			height_q  <= CFG_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN: pattern_q <= pat_t'(cfg_data[2:0]);
				REG_WIDTH:   width_q   <= cfg_data;
				REG_HEIGHT:  height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold off pixels until the geometry pipeline has caught up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	assign busy = (settle_q != 3'd0);
	assign wd   = DIM_W'(width_q);
	assign hd   = DIM_W'(height_q);

	// level 1: divisions by constants, ramp denominator W-1
	dim_t w7_q, w11_q, w6_q, w12_q, w5_q, h5_q, bh_q, top_h_q, mid_h_q, pw_q, pg_q, den_q;
	dim_t pw_raw, pg_raw;

	assign pw_raw = div_rcp(wd, RCP_60);
	assign pg_raw = div_rcp(wd, RCP_80);

	always_ff @(posedge clk) begin
		w7_q    <= div_rcp(wd, RCP_7);
		w11_q   <= div_rcp(wd, RCP_11);
		w6_q    <= div_rcp(wd, RCP_6);
		w12_q   <= div_rcp(wd, RCP_12);
		w5_q    <= div_rcp(wd, RCP_5);
		h5_q    <= div_rcp(hd, RCP_5);
		bh_q    <= div_rcp(hd, RCP_3);
		top_h_q <= div_rcp(hd << 1, RCP_3);
		mid_h_q <= (hd + (hd << 1)) >> 2;
		pw_q    <= (pw_raw == '0) ? DIM_W'(1) : pw_raw;
		pg_q    <= (pg_raw == '0) ? DIM_W'(1) : pg_raw;
		den_q   <= (wd > DIM_W'(1)) ? wd - DIM_W'(1) : DIM_W'(1);
	end

	// level 2: boundaries and cell centers
	logic [5:0][DIM_W-1:0] bar7_q;
	logic [9:0][DIM_W-1:0] bar11_q;
	logic [4:0][DIM_W-1:0] cx_q, cy_q;
	dim_t w6w12_q, cursor_q, right_q, total_q, step_q, band1_q, band2_q, band3_q;
	logic band_ok_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) bar7_q[k] <= DIM_W'(w7_q * DIM_W'(k + 1));
		for (int k = 0; k < 10; k++) bar11_q[k] <= DIM_W'(w11_q * DIM_W'(k + 1));
		for (int g = 0; g < GRID_N; g++) begin
			cx_q[g] <= DIM_W'(w5_q * DIM_W'(g)) + (w5_q >> 1);
			cy_q[g] <= DIM_W'(h5_q * DIM_W'(g)) + (h5_q >> 1);
		end
		w6w12_q   <= w6_q + w12_q;
		cursor_q  <= (w6_q << 1) + w12_q;
		right_q   <= (wd > w12_q) ? wd - w12_q : wd;
		total_q   <= pw_q + (pw_q << 1) + (pg_q << 1);
		step_q    <= pw_q + pg_q;
		band1_q   <= bh_q;
		band2_q   <= bh_q << 1;
		band3_q   <= bh_q + (bh_q << 1);
		band_ok_q <= (bh_q != '0);
	end

	// level 3: pulse start, glyph bounds
	logic                  pulse_ok_q;
	logic [2:0][DIM_W-1:0] pls_q, ple_q;
	logic [4:0][DIM_W-1:0] gx0_q, gx0s_q, gx1_q, gx1s_q, gy0_q, gy1_q, gby_q, gbys_q;
	logic [4:0]            gxv_q, gxr_q, gyv_q, gyb_q;

	always_ff @(posedge clk) begin
		pulse_ok_q <= (right_q > cursor_q + total_q);
		pls_q[0]   <= cursor_q + ((right_q - cursor_q - total_q) >> 1);
		for (int g = 0; g < GRID_N; g++) begin
			gxv_q[g]  <= (cx_q[g] >= HALF_D);
			gx0_q[g]  <= cx_q[g] - HALF_D;
			gx0s_q[g] <= cx_q[g] - HALF_D + STROKE_D;
			gx1_q[g]  <= cx_q[g] + HALF_D;
			gxr_q[g]  <= (cx_q[g] + HALF_D >= STROKE_D);
			gx1s_q[g] <= cx_q[g] + HALF_D - STROKE_D;
			gyv_q[g]  <= (cy_q[g] >= HALF_D);
			gy0_q[g]  <= cy_q[g] - HALF_D;
			gy1_q[g]  <= cy_q[g] + HALF_D;
			gyb_q[g]  <= (cy_q[g] >= SHALF_D);
			gby_q[g]  <= cy_q[g] - SHALF_D;
			gbys_q[g] <= cy_q[g] - SHALF_D + STROKE_D;
		end
	end

	// levels 4 to 6: remaining pulse edges
	always_ff @(posedge clk) begin
		pls_q[1] <= pls_q[0] + step_q;
		pls_q[2] <= pls_q[1] + step_q;
		ple_q[0] <= pls_q[0] + pw_q;
		ple_q[1] <= pls_q[1] + pw_q;
		ple_q[2] <= pls_q[2] + pw_q;
	end

	always_comb begin
		geom.pattern  = pattern_q;
		geom.width    = wd;
		geom.height   = hd;
		geom.den      = den_q;
		geom.bar7     = bar7_q;
		geom.bar11    = bar11_q;
		geom.top_h    = top_h_q;
		geom.mid_h    = mid_h_q;
		geom.w6       = w6_q;
		geom.w6w12    = w6w12_q;
		geom.cursor   = cursor_q;
		geom.right    = right_q;
		geom.pulse_ok = pulse_ok_q;
		geom.pls      = pls_q;
		geom.ple      = ple_q;
		geom.band_ok  = band_ok_q;
		geom.band1    = band1_q;
		geom.band2    = band2_q;
		geom.band3    = band3_q;
		geom.gx0      = gx0_q;
		geom.gx0s     = gx0s_q;
		geom.gx1      = gx1_q;
		geom.gx1s     = gx1s_q;
		geom.gxv      = gxv_q;
		geom.gxr      = gxr_q;
		geom.gy0      = gy0_q;
		geom.gy1      = gy1_q;
		geom.gby      = gby_q;
		geom.gbys     = gbys_q;
		geom.gyv      = gyv_q;
		geom.gyb      = gyb_q;
	end

endmodule

// ===== rtl/vtpg_pixel.sv =====
module vtpg_pixel (
	input  vtpg_pkg::dim_t  x,
	input  vtpg_pkg::dim_t  y,
	input  logic            checker_odd,
	input  logic            on_hatch,
	input  vtpg_pkg::geom_t geom,
	output vtpg_pkg::base_t base
);
	import vtpg_pkg::*;

	logic [2:0]  i7;
	logic [3:0]  i11;
	logic [23:0] smpte_rgb;
	logic        gl_vert, gl_row, gl_bar, gl_bar_row, on_glyph;
	logic [7:0]  lv;

	// bar index: number of bar edges at or left of x
	always_comb begin
		i7  = '0;
		i11 = '0;
		for (int k = 0; k < 6; k++) i7 = i7 + 3'(x >= geom.bar7[k]);
		for (int k = 0; k < 10; k++) i11 = i11 + 4'(x >= geom.bar11[k]);
	end

	// SMPTE bars, earlier region tests take priority over later ones
	always_comb begin
		lv = 8'd0;
		if (y < geom.top_h) begin
			smpte_rgb = top_bar(i7);
		end else if (y < geom.mid_h) begin
			smpte_rgb = mid_bar(i7);
		end else if (x < geom.w6) begin
			smpte_rgb = {8'd0, 8'd0, 8'd76};
		end else if (x < geom.w6w12) begin
			smpte_rgb = WHITE;
		end else if (x < geom.cursor) begin
			smpte_rgb = {8'd72, 8'd0, 8'd130};
		end else if (x >= geom.right) begin
			smpte_rgb = WHITE;
		end else begin
			smpte_rgb = BLACK;
			for (int k = 0; k < 3; k++) begin
				lv = pulse_level(k);
				if (geom.pulse_ok && x >= geom.pls[k] && x < geom.ple[k])
					smpte_rgb = {lv, lv, lv};
			end
		end
	end

	// glyph strokes split into column and row terms per grid column and grid row
	always_comb begin
		gl_vert    = 1'b0;
		gl_row     = 1'b0;
		gl_bar     = 1'b0;
		gl_bar_row = 1'b0;
		for (int g = 0; g < GRID_N; g++) begin
			if (geom.gxv[g]) begin
				if ((x >= geom.gx0[g] && x < geom.gx0s[g]) ||
				    (geom.gxr[g] && x >= geom.gx1s[g] && x < geom.gx1[g]))
					gl_vert = 1'b1;
				if (x >= geom.gx0[g] && x < geom.gx1[g])
					gl_bar = 1'b1;
			end
			if (geom.gyv[g]) begin
				if (y >= geom.gy0[g] && y < geom.gy1[g])
					gl_row = 1'b1;
				if (geom.gyb[g] && y >= geom.gby[g] && y < geom.gbys[g])
					gl_bar_row = 1'b1;
			end
		end
		on_glyph = (gl_vert && gl_row) || (gl_bar && gl_bar_row);
	end

	always_comb begin
		base.rgb     = BLACK;
		base.mask    = 3'b000;
		base.outside = (x >= geom.width) || (y >= geom.height);
		case (geom.pattern)
			PAT_SMPTE:   base.rgb = smpte_rgb;
			PAT_STRIPES: if (!x[0]) base.rgb = WHITE;
			PAT_GRAY:    base.rgb = {3{gray_step(i11)}};
			PAT_CHECKER: if (checker_odd) base.rgb = WHITE;
			PAT_RAMP:    base.mask = 3'b111;
			PAT_RGBRAMP: begin
				if (geom.band_ok && y < geom.band3) begin
					if (y < geom.band1)      base.mask = 3'b100;
					else if (y < geom.band2) base.mask = 3'b010;
					else                     base.mask = 3'b001;
				end
			end
			PAT_HATCH:   if (on_hatch) base.rgb = WHITE;
			PAT_GLYPH:   if (on_glyph) base.rgb = WHITE;
			default: ;
		endcase
		if (base.outside) begin
			base.rgb  = BLACK;
			base.mask = 3'b000;
		end
	end

endmodule

// ===== rtl/vtpg_div.sv =====
module vtpg_div #(
	parameter int NUM_W = 20
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NUM_W-1:0]     num,
	input  vtpg_pkg::dim_t       den,
	output logic [7:0]           quo
);
	import vtpg_pkg::*;

	localparam int EXT_W = NUM_W + 8;

	logic [7:0][NUM_W-1:0] rem_s;
	logic [7:0][7:0]       quo_s;

	// restoring division, one quotient bit per stage, MSB first
	for (genvar i = 0; i < 8; i++) begin : g_step
		logic [NUM_W-1:0] rem_in;
		logic [7:0]       quo_in;
		logic [EXT_W-1:0] dsh;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = 8'd0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign dsh = EXT_W'(den) << (7 - i);

		always_ff @(posedge clk) begin
			if (en) begin
				if (EXT_W'(rem_in) >= dsh) begin
					rem_s[i] <= rem_in - dsh[NUM_W-1:0];
					quo_s[i] <= quo_in | (8'd1 << (7 - i));
				end else begin
					rem_s[i] <= rem_in;
					quo_s[i] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[7];

endmodule

// ===== rtl/video_test_pattern_generator.sv =====
// Video test pattern generator: one pixel coordinate in, its RGB888 color out, for
// SMPTE bars, stripes, gray bars, checkerboard, ramps, crosshatch or an H-glyph grid.
// Fully pipelined: a new word is taken every clock unless the output stalls or the
// geometry settles. The color passes through ten register stages, the depth being
// set by the 8-stage ramp divider (one quotient bit per stage). Coordinates outside
// the frame come out black with outside set. After reset and after any register write
// the input holds ready low while the frame geometry pipeline recomputes its bar and
// glyph edges.
module video_test_pattern_generator #(
	parameter int COORD_BITS   = vtpg_pkg::COORD_BITS_DEF,
	parameter int TILE_PITCH   = vtpg_pkg::TILE_PITCH_DEF,
	parameter int GLYPH_SIZE   = vtpg_pkg::GLYPH_SIZE_DEF,
	parameter int STROKE_WIDTH = vtpg_pkg::STROKE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtpg_pkg::CFG_W-1:0]     cfg_data,
	vtpg_in_if.sink                        pixel_in,
	vtpg_out_if.source                     pixel_out
);
	import vtpg_pkg::*;

	localparam int NUM_W    = COORD_BITS + 8;
	localparam int TP_SHIFT = COORD_BITS + 10;
	localparam int PROD_W   = COORD_BITS + TP_SHIFT + 1;
	// ceil(2^TP_SHIFT / TILE_PITCH): exact tile index and exact remainder-zero test
	localparam logic [TP_SHIFT:0] TP_RCP =
		(TP_SHIFT+1)'(((64'd1 << TP_SHIFT) + 64'(TILE_PITCH) - 64'd1) / 64'(TILE_PITCH));

	geom_t geom;
	logic  busy;
	logic  adv;

	vtpg_setup #(
		.GLYPH_SIZE   (GLYPH_SIZE),
		.STROKE_WIDTH (STROKE_WIDTH)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (busy)
	);

	// whole pipeline moves when the output register is free or being drained
	assign adv            = !pixel_out.valid || pixel_out.ready;
	assign pixel_in.ready = adv && !busy;

	logic [10:1] v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[9:1], pixel_in.valid && !busy};
		end
	end

	// stage 1: capture and multiplies
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [NUM_W-1:0]      num_s1;
	logic [PROD_W-1:0]     prx_s1, pry_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= pixel_in.pixel_x;
			y_s1   <= pixel_in.pixel_y;
			num_s1 <= NUM_W'(pixel_in.pixel_x) * NUM_W'(8'd255);
			prx_s1 <= PROD_W'(pixel_in.pixel_x) * PROD_W'(TP_RCP);
			pry_s1 <= PROD_W'(pixel_in.pixel_y) * PROD_W'(TP_RCP);
		end
	end

	// stage 2: pattern classification
	logic  checker_odd, on_hatch;
	base_t base_now;

	assign checker_odd = prx_s1[TP_SHIFT] ^ pry_s1[TP_SHIFT];
	assign on_hatch    = (prx_s1[TP_SHIFT-1:0] < TP_RCP[TP_SHIFT-1:0]) ||
	                     (pry_s1[TP_SHIFT-1:0] < TP_RCP[TP_SHIFT-1:0]);

	vtpg_pixel u_pixel (
		.x           (DIM_W'(x_s1)),
		.y           (DIM_W'(y_s1)),
		.checker_odd (checker_odd),
		.on_hatch    (on_hatch),
		.geom        (geom),
		.base        (base_now)
	);

	// base color rides alongside the divider, stages 2 to 9
	base_t base_s [2:9];

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s[2] <= base_now;
			for (int k = 3; k <= 9; k++) base_s[k] <= base_s[k-1];
		end
	end

	// stages 2 to 9: ramp value x*255/(W-1)
	logic [7:0] ramp_s9;

	vtpg_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk (clk),
		.en  (adv),
		.num (num_s1),
		.den (geom.den),
		.quo (ramp_s9)
	);

	// stage 10: merge ramp and register the output word
	logic [7:0] red_s10, green_s10, blue_s10;
	logic       outside_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s10     <= base_s[9].mask[2] ? ramp_s9 : base_s[9].rgb[23:16];
			green_s10   <= base_s[9].mask[1] ? ramp_s9 : base_s[9].rgb[15:8];
			blue_s10    <= base_s[9].mask[0] ? ramp_s9 : base_s[9].rgb[7:0];
			outside_s10 <= base_s[9].outside;
		end
	end

	assign pixel_out.valid   = v_s[10];
	assign pixel_out.red     = red_s10;
	assign pixel_out.green   = green_s10;
	assign pixel_out.blue    = blue_s10;
	assign pixel_out.outside = outside_s10;

`ifndef SYNTH
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.outside |->
			pixel_out.red == 8'd0 && pixel_out.green == 8'd0 && pixel_out.blue == 8'd0)
		else $error("outside pixel not black");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pixel_in.ready)
		else $error("input taken while geometry settles");

	a_cfg_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !pixel_in.ready)
		else $error("input ready right after register write");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vtpg_pkg::*;

	localparam int TILE = 64;
	localparam int GLYPH = 64;
	localparam int STROKE = 4;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       outside;
	} color_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	vtpg_in_if #(.COORD_BITS(12)) pixel_in ();
	vtpg_out_if pixel_out ();

	video_test_pattern_generator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel_in(pixel_in.sink), .pixel_out(pixel_out.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the registers
	pat_t cur_pattern;
	int unsigned cur_width;
	int unsigned cur_height;

	color_t expected_colors[$];
	int errors = 0;
	int cycles = 0;

	function automatic int unsigned bar_of(int unsigned x, int unsigned w, int unsigned last);
		int unsigned i;
		if (w == 0) return last;
		i = x / w;
		return (i > last) ? last : i;
	endfunction

	function automatic logic [23:0] smpte_color(int unsigned x, int unsigned y,
		int unsigned W, int unsigned H);
		logic [23:0] top [7];
		logic [23:0] mid [7];
		logic [7:0] lv [3];
		int unsigned i, w0, w1, cursor, right, pw, pg, total, px;
		logic [23:0] c;
		top = '{{8'd191, 8'd191, 8'd191}, {8'd191, 8'd191, 8'd0}, {8'd0, 8'd191, 8'd191},
			{8'd0, 8'd191, 8'd0}, {8'd191, 8'd0, 8'd191}, {8'd191, 8'd0, 8'd0},
			{8'd0, 8'd0, 8'd191}};
		mid = '{{8'd0, 8'd0, 8'd191}, 24'd0, {8'd191, 8'd0, 8'd191}, 24'd0,
			{8'd0, 8'd191, 8'd191}, 24'd0, {8'd191, 8'd191, 8'd191}};
		lv = '{8'd5, 8'd0, 8'd10};
		i = bar_of(x, W / 7, 6);
		if (y < (H * 2) / 3) return top[i];
		if (y < (H * 3) / 4) return mid[i];
		w0 = W / 6;
		w1 = W / 12;
		cursor = w0 + w1 + w0;
		right = (W > w1) ? W - w1 : W;
		if (x < w0) return {8'd0, 8'd0, 8'd76};
		if (x < w0 + w1) return 24'hFFFFFF;
		if (x < cursor) return {8'd72, 8'd0, 8'd130};
		if (x >= right) return 24'hFFFFFF;
		c = 24'd0;
		pw = (W / 60 < 1) ? 1 : W / 60;
		pg = (W / 80 < 1) ? 1 : W / 80;
		total = 3 * pw + 2 * pg;
		if (right > cursor + total) begin
			px = cursor + (right - cursor - total) / 2;
			for (int k = 0; k < 3; k++) begin
				if (x >= px && x < px + pw) c = {3{lv[k]}};
				px += pw + pg;
			end
		end
		return c;
	endfunction

	function automatic bit hit(int unsigned x, int unsigned y, int unsigned x0,
		int unsigned y0, int unsigned x1, int unsigned y1);
		return x >= x0 && x < x1 && y >= y0 && y < y1;
	endfunction

	function automatic bit glyph_hit(int unsigned x, int unsigned y, int unsigned W,
		int unsigned H);
		int unsigned half, cw, ch, cx, cy, x0, y0, x1, y1, by;
		half = GLYPH / 2;
		cw = W / 5;
		ch = H / 5;
		for (int gy = 0; gy < 5; gy++)
			for (int gx = 0; gx < 5; gx++) begin
				cx = gx * cw + cw / 2;
				cy = gy * ch + ch / 2;
				if (cx < half || cy < half) continue;
				x0 = cx - half; y0 = cy - half; x1 = cx + half; y1 = cy + half;
				by = cy - STROKE / 2;
				if (hit(x, y, x0, y0, x0 + STROKE, y1)) return 1;
				if (x1 >= STROKE && hit(x, y, x1 - STROKE, y0, x1, y1)) return 1;
				if (cy >= STROKE / 2 && hit(x, y, x0, by, x1, by + STROKE)) return 1;
			end
		return 0;
	endfunction

	function automatic color_t pixel_color(int unsigned x, int unsigned y);
		int unsigned W, H, den, v, bh, band;
		logic [23:0] c;
		logic [7:0] gs [11];
		color_t r;
		gs = '{8'd0, 8'd26, 8'd51, 8'd77, 8'd102, 8'd128, 8'd153, 8'd179, 8'd204, 8'd230,
			8'd255};
		W = cur_width;
		H = cur_height;
		den = (W > 1) ? W - 1 : 1;
		c = 24'd0;
		r.outside = (x >= W) || (y >= H);
		if (!r.outside) begin
			v = ((x * 255) / den) & 8'hFF;
			case (cur_pattern)
				PAT_SMPTE:   c = smpte_color(x, y, W, H);
				PAT_STRIPES: if (x[0] == 1'b0) c = 24'hFFFFFF;
				PAT_GRAY:    c = {3{gs[bar_of(x, W / 11, 10)]}};
				PAT_CHECKER: if (((x / TILE + y / TILE) & 1) != 0) c = 24'hFFFFFF;
				PAT_RAMP:    c = {3{v[7:0]}};
				PAT_RGBRAMP: begin
					bh = H / 3;
					if (bh != 0 && y < 3 * bh) begin
						band = y / bh;
						c = {(band == 0) ? v[7:0] : 8'd0, (band == 1) ? v[7:0] : 8'd0,
							(band == 2) ? v[7:0] : 8'd0};
					end
				end
				PAT_HATCH:   if (y % TILE == 0 || x % TILE == 0) c = 24'hFFFFFF;
				default:     if (glyph_hit(x, y, W, H)) c = 24'hFFFFFF;
			endcase
		end
		{r.red, r.green, r.blue} = c;
		return r;
	endfunction

	// gap length: mostly short, a few long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		pixel_in.valid = 1'b0;
		pixel_in.pixel_x = '0;
		pixel_in.pixel_y = '0;
		pixel_out.ready = 1'b0;
	end

	// random stall on the result side; runs of full rate in between
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			pixel_out.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				pixel_out.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		color_t got, exp_c;
		cycles <= cycles + 1;
		if (pixel_out.valid && pixel_out.ready) begin
			got = {pixel_out.red, pixel_out.green, pixel_out.blue, pixel_out.outside};
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors <= errors + 1;
			end else begin
				exp_c = expected_colors.pop_front();
				if (got !== exp_c) begin
					$display("%0t: mismatch expected r%0d g%0d b%0d o%0d, got r%0d g%0d b%0d o%0d",
						$time, exp_c.red, exp_c.green, exp_c.blue, exp_c.outside,
						got.red, got.green, got.blue, got.outside);
					errors <= errors + 1;
				end
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// send one coordinate, predict its color when accepted
	task automatic send_pixel(int unsigned x, int unsigned y);
		int g;
		g = gap_len();
		if (g > 0) begin
			pixel_in.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pixel_in.valid <= 1'b1;
		pixel_in.pixel_x <= x[11:0];
		pixel_in.pixel_y <= y[11:0];
		do @(posedge clk); while (!pixel_in.ready);
		// the port only carries the low 12 bits
		expected_colors.push_back(pixel_color(x & 32'h0FFF, y & 32'h0FFF));
	endtask

	task automatic drain();
		pixel_in.valid <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// drives one write for one clock; the caller drops the enable afterwards
	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		case (idx)
			REG_PATTERN: cur_pattern = pat_t'(value[2:0]);
			REG_WIDTH:   cur_width = value & 13'h1FFF;
			default:     cur_height = value & 13'h1FFF;
		endcase
	endtask

	task automatic set_frame(pat_t p, int unsigned w, int unsigned h);
		drain();
		write_reg(REG_PATTERN, p);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// mostly inside the frame, some beyond it, some at the edges
	task automatic random_pixels(int n);
		int unsigned x, y, p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 9);
			if (p < 7) begin
				x = (cur_width > 0) ? $urandom_range(0, (cur_width > 4096 ? 4096 : cur_width) - 1) : 0;
				y = (cur_height > 0) ? $urandom_range(0, (cur_height > 4096 ? 4096 : cur_height) - 1) : 0;
			end else if (p < 9) begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
			end else begin
				x = ($urandom_range(0, 1) != 0) ? 4095 : cur_width;
				y = ($urandom_range(0, 1) != 0) ? 0 : cur_height - 1;
			end
			send_pixel(x, y);
		end
	endtask

	task automatic test_reset_defaults();
		cur_pattern = PAT_SMPTE;
		cur_width = 640;
		cur_height = 480;
		send_pixel(0, 0);
		send_pixel(639, 479);
		send_pixel(640, 0);
		send_pixel(0, 480);
		send_pixel(4095, 4095);
		send_pixel(300, 400);
		send_pixel(330, 470);
	endtask

	task automatic test_directed();
		// each pattern at corners and inside, then degenerate sizes
		for (int p = 0; p < 8; p++) begin
			set_frame(pat_t'(p), 640, 480);
			send_pixel(0, 0);
			send_pixel(64, 240);
			send_pixel(639, 479);
		end
		// zero height: all outside
		set_frame(PAT_STRIPES, 100, 0);
		send_pixel(0, 0);
		// oversize width register: whole coordinate range inside
		set_frame(PAT_RAMP, 8191, 4096);
		send_pixel(4095, 4095);
	endtask

	task automatic test_random_frames();
		int unsigned w, h, sel;
		for (int phase = 0; phase < 24; phase++) begin
			sel = $urandom_range(0, 5);
			case (sel)
				0: begin w = 4096; h = 4096; end
				1: begin w = 1; h = 1; end
				2: begin w = $urandom_range(1, 20); h = $urandom_range(1, 20); end
				3: begin w = 0; h = $urandom_range(0, 8191); end
				4: begin w = $urandom_range(4097, 8191); h = $urandom_range(4097, 8191); end
				default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
			endcase
			set_frame(pat_t'($urandom_range(0, 7)), w, h);
			random_pixels(38);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random_frames();
		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
